// ----- sv/rigid_body_euler_integrator_defines.svh -----
// assertion macros for the rigid body integrator
// used by the controller; needs no other file
`ifndef RIGID_BODY_EULER_INTEGRATOR_DEFINES_SVH
`define RIGID_BODY_EULER_INTEGRATOR_DEFINES_SVH

// same-cycle implication, off while reset is held
`define RBE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define RBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rbe_pkg.sv -----
// shared types, constants and micro-program table of the rigid body integrator
// no dependencies
package rbe_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int MASS_W    = 31;
    localparam int DT_W      = 17;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 4;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int WIDE_W    = DATA_W + FRAC_W + 1;

    localparam logic [MASS_W-1:0]        STATIC_LIMIT    = MASS_W'(7);
    localparam logic [MASS_W-1:0]        INV_MASS_RST    = MASS_W'(65536);
    localparam logic [MASS_W-1:0]        INV_INERTIA_RST = MASS_W'(65536);
    localparam logic signed [DATA_W-1:0] POS_RST         = '0;
    localparam logic signed [DATA_W-1:0] WORD_MAX        = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] WORD_MIN        = {1'b1, {(DATA_W-1){1'b0}}};

    // request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD_FORCE   = 3'd0,
        OP_ADD_TORQUE  = 3'd1,
        OP_CLR_FORCE   = 3'd2,
        OP_CLR_TORQUE  = 3'd3,
        OP_STEP        = 3'd4,
        OP_IMPULSE     = 3'd5,
        OP_IMPULSE_ARM = 3'd6
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_MASS    = 2'd0,
        CFG_INV_INERTIA = 2'd1,
        CFG_START_X     = 2'd2,
        CFG_START_Y     = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL,
        S_WB,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        PROG_STEP,
        PROG_IMPULSE,
        PROG_ARM
    } t_prog;

    // multiplier operand a
    typedef enum logic [3:0] {
        A_FORCE_X,
        A_FORCE_Y,
        A_TORQUE,
        A_TMP,
        A_VEL_X,
        A_VEL_Y,
        A_SPIN,
        A_VEC_X,
        A_VEC_Y,
        A_ARM_X,
        A_ARM_Y
    } t_asel;

    // multiplier operand b
    typedef enum logic [2:0] {
        B_INV_MASS,
        B_INV_INERTIA,
        B_DT,
        B_VEC_X,
        B_VEC_Y
    } t_bsel;

    // where a product goes
    typedef enum logic [3:0] {
        WB_NONE,
        WB_TMP,
        WB_HOLD,
        WB_DIFF,
        WB_VEL_X,
        WB_VEL_Y,
        WB_POS_X,
        WB_POS_Y,
        WB_SPIN,
        WB_ANGLE
    } t_wbsel;

    // updates of the sums that need no multiply
    typedef enum logic [2:0] {
        SIMPLE_NONE,
        SIMPLE_ADD_FORCE,
        SIMPLE_ADD_TORQUE,
        SIMPLE_CLR_FORCE,
        SIMPLE_CLR_TORQUE
    } t_simple;

    typedef struct packed {
        t_asel  a_sel;
        t_bsel  b_sel;
        t_wbsel wb_sel;
        logic   last;
    } t_uop;

    typedef struct packed {
        logic    load_req;
        t_simple simple;
        logic    mul_en;
        t_asel   a_sel;
        t_bsel   b_sel;
        t_wbsel  wb_sel;
        logic    clr_sums;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_static;
    } t_status;

    // micro-program: one multiply and one write-back per entry
    function automatic t_uop uop_fetch(input t_prog prog, input logic [STEP_W-1:0] idx);
        t_uop u;
        u = '{A_TMP, B_DT, WB_NONE, 1'b1};
        unique case (prog)
            PROG_STEP: begin
                case (idx)
                    4'd0: u = '{A_FORCE_X, B_INV_MASS,    WB_TMP,   1'b0};
                    4'd1: u = '{A_TMP,     B_DT,          WB_VEL_X, 1'b0};
                    4'd2: u = '{A_FORCE_Y, B_INV_MASS,    WB_TMP,   1'b0};
                    4'd3: u = '{A_TMP,     B_DT,          WB_VEL_Y, 1'b0};
                    4'd4: u = '{A_VEL_X,   B_DT,          WB_POS_X, 1'b0};
                    4'd5: u = '{A_VEL_Y,   B_DT,          WB_POS_Y, 1'b0};
                    4'd6: u = '{A_TORQUE,  B_INV_INERTIA, WB_TMP,   1'b0};
                    4'd7: u = '{A_TMP,     B_DT,          WB_SPIN,  1'b0};
                    4'd8: u = '{A_SPIN,    B_DT,          WB_ANGLE, 1'b1};
                    default: u = '{A_TMP, B_DT, WB_NONE, 1'b1};
                endcase
            end
            PROG_IMPULSE: begin
                case (idx)
                    4'd0: u = '{A_VEC_X, B_INV_MASS, WB_VEL_X, 1'b0};
                    4'd1: u = '{A_VEC_Y, B_INV_MASS, WB_VEL_Y, 1'b1};
                    default: u = '{A_TMP, B_DT, WB_NONE, 1'b1};
                endcase
            end
            PROG_ARM: begin
                case (idx)
                    4'd0: u = '{A_VEC_X, B_INV_MASS,    WB_VEL_X, 1'b0};
                    4'd1: u = '{A_VEC_Y, B_INV_MASS,    WB_VEL_Y, 1'b0};
                    4'd2: u = '{A_ARM_X, B_VEC_Y,       WB_HOLD,  1'b0};
                    4'd3: u = '{A_ARM_Y, B_VEC_X,       WB_DIFF,  1'b0};
                    4'd4: u = '{A_TMP,   B_INV_INERTIA, WB_SPIN,  1'b1};
                    default: u = '{A_TMP, B_DT, WB_NONE, 1'b1};
                endcase
            end
            default: u = '{A_TMP, B_DT, WB_NONE, 1'b1};
        endcase
        return u;
    endfunction

endpackage

// ----- sv/rbe_if.sv -----
// request, result and configuration channels of the rigid body integrator
// depends on rbe_pkg
interface rbe_in_if
    import rbe_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] torque_in;
    logic signed [DATA_W-1:0] arm_x;
    logic signed [DATA_W-1:0] arm_y;
    logic [DT_W-1:0]          time_step;

    modport source (output valid, op, vec_x, vec_y, torque_in, arm_x, arm_y, time_step,
                    input ready);
    modport sink   (input valid, op, vec_x, vec_y, torque_in, arm_x, arm_y, time_step,
                    output ready);
endinterface

interface rbe_out_if
    import rbe_pkg::*;
    ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] vel_x;
    logic signed [DATA_W-1:0] vel_y;
    logic signed [DATA_W-1:0] angle;
    logic signed [DATA_W-1:0] spin;
    logic                     is_static;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, angle, spin, is_static,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, angle, spin, is_static,
                    output ready);
endinterface

interface rbe_cfg_if
    import rbe_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/rbe_datapath.sv -----
// body state, shared multiplier and saturating write-back of the integrator
// depends on rbe_pkg; driven by rbe_ctrl through t_cmd
module rbe_datapath
    import rbe_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [OP_W-1:0]          i_op,
    input  logic signed [DATA_W-1:0] i_vec_x,
    input  logic signed [DATA_W-1:0] i_vec_y,
    input  logic signed [DATA_W-1:0] i_torque_in,
    input  logic signed [DATA_W-1:0] i_arm_x,
    input  logic signed [DATA_W-1:0] i_arm_y,
    input  logic [DT_W-1:0]          i_time_step,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data,
    output logic signed [DATA_W-1:0] o_pos_x,
    output logic signed [DATA_W-1:0] o_pos_y,
    output logic signed [DATA_W-1:0] o_vel_x,
    output logic signed [DATA_W-1:0] o_vel_y,
    output logic signed [DATA_W-1:0] o_angle,
    output logic signed [DATA_W-1:0] o_spin,
    output logic                     o_is_static
);

    // saturate a wide floor-shifted value to the word
    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (!v[WIDE_W-1] && (|v[WIDE_W-2:DATA_W-1])) begin
            r = WORD_MAX;
        end else if (v[WIDE_W-1] && !(&v[WIDE_W-2:DATA_W-1])) begin
            r = WORD_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // saturating add
    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0]   s;
        logic signed [DATA_W-1:0] r;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? WORD_MIN : WORD_MAX;
        end else begin
            r = s[DATA_W-1:0];
        end
        return r;
    endfunction

    // latched request
    logic [OP_W-1:0]          r_op;
    logic signed [DATA_W-1:0] r_vec_x, r_vec_y, r_torque_in, r_arm_x, r_arm_y;
    logic [DT_W-1:0]          r_time_step;

    // configuration and body state
    logic [MASS_W-1:0]        r_inv_mass, r_inv_inertia;
    logic signed [DATA_W-1:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_angle, r_spin;
    logic signed [DATA_W-1:0] r_force_x, r_force_y, r_torque;

    // multiplier and scratch
    logic signed [DATA_W-1:0] r_tmp;
    logic signed [PROD_W-1:0] r_prod, r_hold;

    // result register
    logic signed [DATA_W-1:0] r_out_pos_x, r_out_pos_y, r_out_vel_x, r_out_vel_y;
    logic signed [DATA_W-1:0] r_out_angle, r_out_spin;
    logic                     r_out_static;

    logic signed [DATA_W-1:0] w_a, w_b, w_q, w_diff_q, w_acc_base, w_acc;
    logic signed [PROD_W:0]   w_diff;
    logic                     w_static;

    assign w_static = (r_inv_mass < STATIC_LIMIT);
    assign o_status = '{op: r_op, is_static: w_static};

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op        <= i_op;
            r_vec_x     <= i_vec_x;
            r_vec_y     <= i_vec_y;
            r_torque_in <= i_torque_in;
            r_arm_x     <= i_arm_x;
            r_arm_y     <= i_arm_y;
            r_time_step <= i_time_step;
        end
    end

    // operand selection
    always_comb begin
        unique case (i_cmd.a_sel)
            A_FORCE_X: w_a = r_force_x;
            A_FORCE_Y: w_a = r_force_y;
            A_TORQUE:  w_a = r_torque;
            A_TMP:     w_a = r_tmp;
            A_VEL_X:   w_a = r_vel_x;
            A_VEL_Y:   w_a = r_vel_y;
            A_SPIN:    w_a = r_spin;
            A_VEC_X:   w_a = r_vec_x;
            A_VEC_Y:   w_a = r_vec_y;
            A_ARM_X:   w_a = r_arm_x;
            A_ARM_Y:   w_a = r_arm_y;
            default:   w_a = r_tmp;
        endcase
        unique case (i_cmd.b_sel)
            B_INV_MASS:    w_b = {{(DATA_W-MASS_W){1'b0}}, r_inv_mass};
            B_INV_INERTIA: w_b = {{(DATA_W-MASS_W){1'b0}}, r_inv_inertia};
            B_DT:          w_b = {{(DATA_W-DT_W){1'b0}}, r_time_step};
            B_VEC_X:       w_b = r_vec_x;
            B_VEC_Y:       w_b = r_vec_y;
            default:       w_b = r_vec_x;
        endcase
    end

    // shared multiplier, product registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= w_a * w_b;
        end
    end

    // floor shift and saturate, cross product difference, accumulate
    assign w_q      = sat_wide({r_prod[PROD_W-1], r_prod[PROD_W-1:FRAC_W]});
    assign w_diff   = {r_hold[PROD_W-1], r_hold} - {r_prod[PROD_W-1], r_prod};
    assign w_diff_q = sat_wide(w_diff[PROD_W:FRAC_W]);

    always_comb begin
        unique case (i_cmd.wb_sel)
            WB_VEL_X: w_acc_base = r_vel_x;
            WB_VEL_Y: w_acc_base = r_vel_y;
            WB_POS_X: w_acc_base = r_pos_x;
            WB_POS_Y: w_acc_base = r_pos_y;
            WB_SPIN:  w_acc_base = r_spin;
            WB_ANGLE: w_acc_base = r_angle;
            default:  w_acc_base = r_vel_x;
        endcase
    end
    assign w_acc = sat_add(w_acc_base, w_q);

    // scratch registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.wb_sel)
            WB_TMP:  r_tmp  <= w_q;
            WB_HOLD: r_hold <= r_prod;
            WB_DIFF: r_tmp  <= w_diff_q;
            default: ;
        endcase
    end

    // configuration and body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass    <= INV_MASS_RST;
            r_inv_inertia <= INV_INERTIA_RST;
            r_pos_x       <= POS_RST;
            r_pos_y       <= POS_RST;
            r_vel_x       <= '0;
            r_vel_y       <= '0;
            r_angle       <= '0;
            r_spin        <= '0;
            r_force_x     <= '0;
            r_force_y     <= '0;
            r_torque      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_INV_MASS:    r_inv_mass    <= i_cfg_data[MASS_W-1:0];
                    CFG_INV_INERTIA: r_inv_inertia <= i_cfg_data[MASS_W-1:0];
                    CFG_START_X:     r_pos_x       <= i_cfg_data;
                    CFG_START_Y:     r_pos_y       <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (i_cmd.simple)
                SIMPLE_ADD_FORCE: begin
                    r_force_x <= sat_add(r_force_x, r_vec_x);
                    r_force_y <= sat_add(r_force_y, r_vec_y);
                end
                SIMPLE_ADD_TORQUE: r_torque <= sat_add(r_torque, r_torque_in);
                SIMPLE_CLR_FORCE: begin
                    r_force_x <= '0;
                    r_force_y <= '0;
                end
                SIMPLE_CLR_TORQUE: r_torque <= '0;
                default: ;
            endcase
            unique case (i_cmd.wb_sel)
                WB_VEL_X: r_vel_x <= w_acc;
                WB_VEL_Y: r_vel_y <= w_acc;
                WB_POS_X: r_pos_x <= w_acc;
                WB_POS_Y: r_pos_y <= w_acc;
                WB_SPIN:  r_spin  <= w_acc;
                WB_ANGLE: r_angle <= w_acc;
                default: ;
            endcase
            if (i_cmd.clr_sums) begin
                r_force_x <= '0;
                r_force_y <= '0;
                r_torque  <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pos_x  <= r_pos_x;
            r_out_pos_y  <= r_pos_y;
            r_out_vel_x  <= r_vel_x;
            r_out_vel_y  <= r_vel_y;
            r_out_angle  <= r_angle;
            r_out_spin   <= r_spin;
            r_out_static <= w_static;
        end
    end

    assign o_pos_x     = r_out_pos_x;
    assign o_pos_y     = r_out_pos_y;
    assign o_vel_x     = r_out_vel_x;
    assign o_vel_y     = r_out_vel_y;
    assign o_angle     = r_out_angle;
    assign o_spin      = r_out_spin;
    assign o_is_static = r_out_static;

endmodule

// ----- sv/rbe_ctrl.sv -----
// sequencer of the integrator: decodes a request and walks its micro-program
// depends on rbe_pkg and rigid_body_euler_integrator_defines.svh
`include "rigid_body_euler_integrator_defines.svh"

module rbe_ctrl
    import rbe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state              r_state, n_state;
    t_prog               r_prog, n_prog;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;
    t_uop                w_uop;
    logic                w_in_fire, w_slot_free, w_long_op;

    assign w_uop       = uop_fetch(r_prog, r_step);
    assign w_in_fire   = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_long_op   = (i_status.op == OP_STEP) || (i_status.op == OP_IMPULSE)
                         || (i_status.op == OP_IMPULSE_ARM);

    // next state
    always_comb begin
        n_state = r_state;
        n_prog  = r_prog;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_step = '0;
                priority case (t_op'(i_status.op))
                    OP_STEP:        n_prog = PROG_STEP;
                    OP_IMPULSE:     n_prog = PROG_IMPULSE;
                    OP_IMPULSE_ARM: n_prog = PROG_ARM;
                    default:        n_prog = r_prog;
                endcase
                n_state = (w_long_op && !i_status.is_static) ? S_MUL : S_FINISH;
            end
            S_MUL: n_state = S_WB;
            S_WB: begin
                if (w_uop.last) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_MUL;
                    n_step  = r_step + STEP_W'(1);
                end
            end
            S_FINISH: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (r_state == S_FINISH && w_slot_free) n_out_valid = 1'b1;
    end

    // command outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.simple   = SIMPLE_NONE;
        o_cmd.a_sel    = w_uop.a_sel;
        o_cmd.b_sel    = w_uop.b_sel;
        o_cmd.wb_sel   = WB_NONE;
        o_cmd.load_req = w_in_fire;
        unique case (r_state)
            S_DISPATCH: begin
                priority case (t_op'(i_status.op))
                    OP_ADD_FORCE:  o_cmd.simple = SIMPLE_ADD_FORCE;
                    OP_ADD_TORQUE: o_cmd.simple = SIMPLE_ADD_TORQUE;
                    OP_CLR_FORCE:  o_cmd.simple = SIMPLE_CLR_FORCE;
                    OP_CLR_TORQUE: o_cmd.simple = SIMPLE_CLR_TORQUE;
                    default:       o_cmd.simple = SIMPLE_NONE;
                endcase
            end
            S_MUL: o_cmd.mul_en = 1'b1;
            S_WB: begin
                o_cmd.wb_sel   = w_uop.wb_sel;
                o_cmd.clr_sums = w_uop.last && (r_prog == PROG_STEP);
            end
            S_FINISH: o_cmd.out_load = w_slot_free;
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prog      <= PROG_STEP;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prog      <= n_prog;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // checks
    `RBE_ASSERT_NEXT(a_fire_dispatch, i_clk, i_rst_n, w_in_fire, r_state == S_DISPATCH, "request not dispatched")
    `RBE_ASSERT_NEXT(a_last_finish, i_clk, i_rst_n, (r_state == S_WB) && w_uop.last, r_state == S_FINISH, "program did not end")
    `RBE_ASSERT_NEXT(a_static_skip, i_clk, i_rst_n, (r_state == S_DISPATCH) && i_status.is_static, r_state == S_FINISH, "static body ran a program")
    `RBE_ASSERT_NEXT(a_finish_hold, i_clk, i_rst_n, (r_state == S_FINISH) && r_out_valid && !i_out_ready, r_state == S_FINISH, "result slot overwritten")

endmodule

// ----- sv/rigid_body_euler_integrator.sv -----
// top level of the 2D rigid body semi-implicit Euler integrator
// depends on rbe_pkg, rbe_if, rbe_ctrl and rbe_datapath
//
//  channel   direction  contents
//  i_req     in         op, vec_x, vec_y, torque_in, arm_x, arm_y, time_step
//  o_res     out        pos_x, pos_y, vel_x, vel_y, angle, spin, is_static
//  i_cfg     in         index (0 inv_mass, 1 inv_inertia, 2 start_x, 3 start_y), data
//
// force, torque and clear requests, unused codes and any step or impulse on a
// static body pass only the dispatch and finish states from accept to result;
// an impulse, an impulse at an arm and a step add a multiply and a write-back
// state for each product on the single shared 32x32 multiplier (9 for a step)
// a new request is taken while the previous result still waits in o_res
// reset is synchronous and loads the register defaults; cfg is always ready
module rigid_body_euler_integrator
    import rbe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbe_in_if.sink    i_req,
    rbe_out_if.source o_res,
    rbe_cfg_if.sink   i_cfg
);

    t_cmd    w_cmd;
    t_status w_status;

    assign i_cfg.ready = 1'b1;

    rbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rbe_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_op        (i_req.op),
        .i_vec_x     (i_req.vec_x),
        .i_vec_y     (i_req.vec_y),
        .i_torque_in (i_req.torque_in),
        .i_arm_x     (i_req.arm_x),
        .i_arm_y     (i_req.arm_y),
        .i_time_step (i_req.time_step),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_pos_x     (o_res.pos_x),
        .o_pos_y     (o_res.pos_y),
        .o_vel_x     (o_res.vel_x),
        .o_vel_y     (o_res.vel_y),
        .o_angle     (o_res.angle),
        .o_spin      (o_res.spin),
        .o_is_static (o_res.is_static)
    );

endmodule
